// ----- rtl/tsp_pkg.sv -----
// Shared constants, codes and types for the tone sequence player.
package tsp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int NOTE_DEPTH  = 256;
  localparam int NOTE_AW     = $clog2(NOTE_DEPTH);
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int FREQ_W = 16;
  localparam int DUR_W  = 16;
  localparam int NOTE_W = FREQ_W + DUR_W;
  localparam int SONG_W = 8;
  localparam int TIME_W = 32;

  // 65535 * 23.84 folded into an integer numerator
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0]  PERIOD_NUM   = 21'd1562354;
  localparam logic [FREQ_W-1:0] MIN_FREQ     = 16'd25;
  localparam logic [FREQ_W-1:0] PERIOD_RESET = 16'd34464;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_QUEUE = 2'd1,
    OP_START = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FETCH = 2'd1,
    PH_WAIT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic              go;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/tone_sequence_player.sv -----
// Tone sequence player top level: song queue, player sequencer, note memory.
//
// channel   signals                                   transfer
// command   start, busy, operation, time_now,         start high, busy low
//           song_start, note_address, note_frequency,
//           note_duration
// result    done, accepted, tone_enable, tone_period, done high, one cycle
//           player_phase, queue_level
//
// Queue, start, write and non-fetch ticks: result in the cycle after the transfer,
// busy stays low. A tick in the fetch phase reads the note memory;
// a tone note then runs the 21-step serial divider.
// Reset (rst, synchronous) clears the player to idle, empty queue, tone frozen;
// the note memory and queue slots are not cleared. Results cannot be stalled.
module tone_sequence_player (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [31:0] time_now,
  input  logic [7:0]  song_start,
  input  logic [7:0]  note_address,
  input  logic [15:0] note_frequency,
  input  logic [15:0] note_duration,
  output logic        done,
  output logic        accepted,
  output logic        tone_enable,
  output logic [15:0] tone_period,
  output logic [1:0]  player_phase,
  output logic [2:0]  queue_level
);

  typedef enum logic [1:0] {
    T_READY,
    T_READ,
    T_DIV
  } state_t;

  state_t                        state;
  tsp_pkg::phase_t               phase;
  logic [tsp_pkg::SONG_W-1:0]    song_queue [tsp_pkg::QUEUE_DEPTH];
  logic [tsp_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [tsp_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [tsp_pkg::FILL_W-1:0]    fill;
  logic [tsp_pkg::SONG_W-1:0]    song_base;
  logic [tsp_pkg::NOTE_AW-1:0]   note_offset;
  logic [tsp_pkg::DUR_W-1:0]     hold_time;
  logic [tsp_pkg::TIME_W-1:0]    phase_start;
  logic [tsp_pkg::TIME_W-1:0]    tick_time;
  logic                          tone_running;
  logic [tsp_pkg::FREQ_W-1:0]    period;

  logic                          accept;
  tsp_pkg::op_t                  op_in;
  logic [tsp_pkg::NOTE_AW-1:0]   note_ptr;
  logic [tsp_pkg::NOTE_AW-1:0]   ram_addr;
  logic                          ram_we;
  logic [tsp_pkg::NOTE_W-1:0]    ram_rdata;
  logic [tsp_pkg::FREQ_W-1:0]    rd_freq;
  logic [tsp_pkg::DUR_W-1:0]     rd_dur;
  logic                          note_end;
  logic                          note_low;
  logic [tsp_pkg::TIME_W-1:0]    elapsed;
  logic                          wait_over;
  logic                          queue_full;
  tsp_pkg::div_req_t             div_req;
  tsp_pkg::div_rsp_t             div_rsp;

  function automatic logic [tsp_pkg::QUEUE_AW-1:0] q_inc(
    input logic [tsp_pkg::QUEUE_AW-1:0] ptr
  );
    return (ptr == tsp_pkg::QUEUE_AW'(tsp_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign busy   = (state != T_READY);
  assign accept = start && !busy;
  assign op_in  = tsp_pkg::op_t'(operation);

  assign note_ptr = tsp_pkg::NOTE_AW'(song_base) + note_offset;
  assign ram_addr = (op_in == tsp_pkg::OP_WRITE) ? tsp_pkg::NOTE_AW'(note_address) : note_ptr;
  assign ram_we   = accept && (op_in == tsp_pkg::OP_WRITE);

  tsp_ram #(
    .WIDTH(tsp_pkg::NOTE_W),
    .DEPTH(tsp_pkg::NOTE_DEPTH)
  ) u_note_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({note_duration, note_frequency}),
    .rdata(ram_rdata)
  );

  assign rd_freq  = ram_rdata[tsp_pkg::FREQ_W-1:0];
  assign rd_dur   = ram_rdata[tsp_pkg::NOTE_W-1:tsp_pkg::FREQ_W];
  assign note_end = (rd_freq == '0) && (rd_dur == '0);
  assign note_low = rd_freq < tsp_pkg::MIN_FREQ;

  assign elapsed    = time_now - phase_start;
  assign wait_over  = elapsed >= tsp_pkg::TIME_W'(hold_time);
  assign queue_full = (fill == tsp_pkg::FILL_W'(tsp_pkg::QUEUE_DEPTH));

  assign div_req.go      = (state == T_READ) && !note_end && !note_low;
  assign div_req.divisor = rd_freq;

  tsp_divider u_divider (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_READY;
      phase        <= tsp_pkg::PH_IDLE;
      rd_ptr       <= '0;
      wr_ptr       <= '0;
      fill         <= '0;
      song_base    <= '0;
      note_offset  <= '0;
      hold_time    <= '0;
      phase_start  <= '0;
      tone_running <= 1'b0;
      period       <= tsp_pkg::PERIOD_RESET;
      done         <= 1'b0;
      accepted     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_READY: begin
          if (accept) begin
            done     <= 1'b1;
            accepted <= 1'b0;
            case (op_in)
              tsp_pkg::OP_TICK: begin
                case (phase)
                  tsp_pkg::PH_FETCH: begin
                    // note word comes back from the RAM next cycle
                    done      <= 1'b0;
                    tick_time <= time_now;
                    state     <= T_READ;
                  end
                  tsp_pkg::PH_WAIT: begin
                    if (wait_over) begin
                      note_offset <= note_offset + 1'b1;
                      phase       <= tsp_pkg::PH_FETCH;
                      phase_start <= time_now;
                    end
                  end
                  default: ;
                endcase
              end
              tsp_pkg::OP_QUEUE: begin
                if (!queue_full) begin
                  accepted <= 1'b1;
                  wr_ptr   <= q_inc(wr_ptr);
                  if (phase == tsp_pkg::PH_IDLE) begin
                    // queue is empty when idle: push and pop in one go
                    rd_ptr      <= q_inc(rd_ptr);
                    song_base   <= song_start;
                    note_offset <= '0;
                    phase       <= tsp_pkg::PH_FETCH;
                  end else begin
                    song_queue[wr_ptr] <= song_start;
                    fill               <= fill + 1'b1;
                  end
                end
              end
              tsp_pkg::OP_START: begin
                if (phase == tsp_pkg::PH_IDLE) begin
                  accepted    <= 1'b1;
                  song_base   <= song_start;
                  note_offset <= '0;
                  phase       <= tsp_pkg::PH_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        T_READ: begin
          if (note_end) begin
            tone_running <= 1'b0;
            note_offset  <= '0;
            if (fill != '0) begin
              song_base <= song_queue[rd_ptr];
              rd_ptr    <= q_inc(rd_ptr);
              fill      <= fill - 1'b1;
              phase     <= tsp_pkg::PH_FETCH;
            end else begin
              phase <= tsp_pkg::PH_IDLE;
            end
            done  <= 1'b1;
            state <= T_READY;
          end else if (note_low) begin
            tone_running <= 1'b0;
            hold_time    <= rd_dur;
            phase        <= tsp_pkg::PH_WAIT;
            phase_start  <= tick_time;
            done         <= 1'b1;
            state        <= T_READY;
          end else begin
            hold_time <= rd_dur;
            state     <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_rsp.done) begin
            period       <= div_rsp.quotient;
            tone_running <= 1'b1;
            phase        <= tsp_pkg::PH_WAIT;
            phase_start  <= tick_time;
            done         <= 1'b1;
            state        <= T_READY;
          end
        end
        default: state <= T_READY;
      endcase
    end
  end

  assign tone_enable  = tone_running;
  assign tone_period  = period;
  assign player_phase = phase;
  assign queue_level  = 3'(fill);

endmodule

// ----- rtl/tsp_ram.sv -----
// Generic single-port RAM with registered read.
module tsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/tsp_divider.sv -----
// Bit-serial restoring divider: fixed period numerator over the note frequency.
module tsp_divider (
  input  logic              clk,
  input  logic              rst,
  input  tsp_pkg::div_req_t req,
  output tsp_pkg::div_rsp_t rsp
);

  logic                           running;
  logic                           done;
  logic [tsp_pkg::DIV_CNT_W-1:0]  count;
  logic [tsp_pkg::FREQ_W-1:0]     rem;
  logic [tsp_pkg::FREQ_W-1:0]     dvsr;
  logic [tsp_pkg::DIV_W-1:0]      dvd;
  logic [tsp_pkg::DIV_W-1:0]      quo;

  logic [tsp_pkg::FREQ_W:0]       trial;
  logic [tsp_pkg::FREQ_W:0]       diff;
  logic                           fits;

  // one quotient bit per cycle, numerator shifted out MSB first
  assign trial = {rem, dvd[tsp_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        dvsr    <= req.divisor;
        rem     <= '0;
        dvd     <= tsp_pkg::PERIOD_NUM;
        quo     <= '0;
        count   <= tsp_pkg::DIV_CNT_W'(tsp_pkg::DIV_W - 1);
        running <= 1'b1;
      end else if (running) begin
        rem <= fits ? diff[tsp_pkg::FREQ_W-1:0] : trial[tsp_pkg::FREQ_W-1:0];
        dvd <= {dvd[tsp_pkg::DIV_W-2:0], 1'b0};
        quo <= {quo[tsp_pkg::DIV_W-2:0], fits};
        if (count == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo[tsp_pkg::FREQ_W-1:0];

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the tone sequence player: command driver, result monitor, predictor.
module tb_top;
  import tsp_pkg::*;

  localparam int PER_PHASE   = 270;
  localparam int TAIL_CYCLES = 40;
  localparam int STALL_LIMIT = 4000;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    logic [7:0]  song;
    logic [7:0]  addr;
    logic [15:0] freq;
    logic [15:0] dur;
  } player_cmd_t;

  typedef struct {
    logic        acc;
    logic        tone;
    logic [15:0] period;
    phase_t      phase;
    logic [2:0]  level;
  } player_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = OP_TICK;
  logic [31:0] time_now = '0;
  logic [7:0]  song_start = '0;
  logic [7:0]  note_address = '0;
  logic [15:0] note_frequency = '0;
  logic [15:0] note_duration = '0;
  logic        done;
  logic        accepted;
  logic        tone_enable;
  logic [15:0] tone_period;
  logic [1:0]  player_phase;
  logic [2:0]  queue_level;

  tone_sequence_player dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .time_now(time_now), .song_start(song_start),
    .note_address(note_address), .note_frequency(note_frequency),
    .note_duration(note_duration), .done(done), .accepted(accepted),
    .tone_enable(tone_enable), .tone_period(tone_period),
    .player_phase(player_phase), .queue_level(queue_level)
  );

  always #2 clk = ~clk;

  // player shadow state
  logic [31:0] note_shadow [NOTE_DEPTH];
  logic [7:0]  song_ring [QUEUE_DEPTH];
  int          ring_rd = 0;
  int          ring_wr = 0;
  int          ring_fill = 0;
  phase_t      play_phase = PH_IDLE;
  logic [7:0]  song_base = '0;
  logic [7:0]  note_offs = '0;
  logic [15:0] hold_ms = '0;
  logic [31:0] phase_t0 = '0;
  logic        tone_on = 1'b0;
  logic [15:0] period_val = PERIOD_RESET;

  player_cmd_t    command_backlog[$];
  player_status_t predicted_status[$];
  player_cmd_t    on_port;
  logic [7:0]     song_heads[$];
  logic [31:0]    clock_ms = 32'hFFFF_FFFD;
  int             send_idle_pct = 0;
  int             mismatches = 0;
  int             quiet_cycles = 0;

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH @%0t: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void pop_next_song();
    song_base = song_ring[ring_rd];
    ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
    ring_fill--;
    note_offs = '0;
    play_phase = PH_FETCH;
  endfunction

  function automatic void advance_on_tick(logic [31:0] now);
    logic [15:0] f;
    logic [15:0] d;
    logic [31:0] elapsed;
    if (play_phase == PH_FETCH) begin
      {d, f} = note_shadow[8'(song_base + note_offs)];
      if (f == 0 && d == 0) begin
        // end of song: freeze, then next queued song or idle
        tone_on = 1'b0;
        note_offs = '0;
        if (ring_fill > 0) pop_next_song();
        else play_phase = PH_IDLE;
      end else begin
        if (f < MIN_FREQ) begin
          tone_on = 1'b0;
        end else begin
          period_val = 16'(32'(PERIOD_NUM) / 32'(f));
          tone_on = 1'b1;
        end
        hold_ms = d;
        play_phase = PH_WAIT;
        phase_t0 = now;
      end
    end else if (play_phase == PH_WAIT) begin
      elapsed = now - phase_t0;
      if (elapsed >= 32'(hold_ms)) begin
        note_offs = note_offs + 8'd1;
        play_phase = PH_FETCH;
        phase_t0 = now;
      end
    end
  endfunction

  function automatic player_status_t play_command(player_cmd_t c);
    player_status_t r;
    r.acc = 1'b0;
    case (c.op)
      OP_TICK: advance_on_tick(c.now);
      OP_QUEUE: begin
        if (ring_fill < QUEUE_DEPTH) begin
          song_ring[ring_wr] = c.song;
          ring_wr = (ring_wr + 1) % QUEUE_DEPTH;
          ring_fill++;
          r.acc = 1'b1;
          if (play_phase == PH_IDLE) pop_next_song();
        end
      end
      OP_START: begin
        if (play_phase == PH_IDLE) begin
          song_base = c.song;
          note_offs = '0;
          play_phase = PH_FETCH;
          r.acc = 1'b1;
        end
      end
      default: note_shadow[c.addr] = {c.dur, c.freq};
    endcase
    r.tone = tone_on;
    r.period = period_val;
    r.phase = play_phase;
    r.level = 3'(ring_fill);
    return r;
  endfunction

  // driver: predict on each transfer, then present the next command
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predicted_status.push_back(play_command(on_port));
      if (!start || !busy) begin
        if (command_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_port = command_backlog.pop_front();
          operation <= on_port.op;
          time_now <= on_port.now;
          song_start <= on_port.song;
          note_address <= on_port.addr;
          note_frequency <= on_port.freq;
          note_duration <= on_port.dur;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : result_check
    player_status_t want;
    if (!rst && done) begin
      if (predicted_status.size() == 0) begin
        report_mismatch("unexpected result, queue_level", queue_level, 0);
      end else begin
        want = predicted_status.pop_front();
        if (accepted !== want.acc) report_mismatch("accepted", accepted, want.acc);
        if (tone_enable !== want.tone) report_mismatch("tone_enable", tone_enable, want.tone);
        if (tone_period !== want.period) report_mismatch("tone_period", tone_period, want.period);
        if (player_phase !== want.phase) report_mismatch("player_phase", player_phase, want.phase);
        if (queue_level !== want.level) report_mismatch("queue_level", queue_level, want.level);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TIMEOUT: no transfer for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic push_cmd(op_t op, logic [7:0] song, logic [7:0] addr,
                          logic [15:0] freq, logic [15:0] dur);
    player_cmd_t c;
    c.op = op;
    c.now = (op == OP_TICK) ? clock_ms : $urandom;
    c.song = song;
    c.addr = addr;
    c.freq = freq;
    c.dur = dur;
    command_backlog.push_back(c);
  endtask

  task automatic push_tick(int unsigned dt);
    clock_ms = clock_ms + dt;
    push_cmd(OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] pick_freq();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom);
    if (r < 60) return 16'($urandom_range(25, 2000));
    if (r < 75) return 16'($urandom_range(0, 24));
    if (r < 85) return 16'd0;
    if (r < 90) return MIN_FREQ;
    if (r < 95) return 16'hFFFF;
    return 16'($urandom_range(1, 100));
  endfunction

  function automatic logic [15:0] pick_dur();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 16'($urandom_range(0, 4));
    if (r < 85) return 16'($urandom_range(0, 15));
    if (r < 95) return 16'($urandom);
    return 16'hFFFF;
  endfunction

  task automatic push_random_command();
    int r;
    int s;
    logic [7:0] a;
    r = $urandom_range(99);
    if (r < 62) begin
      s = $urandom_range(99);
      if (s < 70) push_tick($urandom_range(0, 3));
      else if (s < 85) push_tick($urandom_range(0, 20));
      else if (s < 95) push_tick($urandom_range(0, 70000));
      else begin
        // time jump anywhere, including backwards
        clock_ms = $urandom;
        push_tick(0);
      end
    end else if (r < 82) begin
      if ($urandom_range(3) != 0) a = song_heads[$urandom_range(song_heads.size() - 1)];
      else a = 8'($urandom);
      push_cmd((r < 74) ? OP_QUEUE : OP_START, a, 8'($urandom), 16'($urandom),
               16'($urandom));
    end else begin
      if ($urandom_range(9) < 6)
        a = song_heads[$urandom_range(song_heads.size() - 1)] + 8'($urandom_range(0, 4));
      else a = 8'($urandom);
      if ($urandom_range(99) < 15) push_cmd(OP_WRITE, 8'($urandom), a, 16'd0, 16'd0);
      else push_cmd(OP_WRITE, 8'($urandom), a, pick_freq(), pick_dur());
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (command_backlog.size() != 0 || start || predicted_status.size() != 0);
  endtask

  initial begin : stimulus
    int idle_plan[4];
    int left;
    idle_plan = '{0, 83, 0, 25};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: tick while idle, a song that wraps the note address
    push_tick(0);
    push_cmd(OP_WRITE, 8'd0, 8'd254, 16'hFFFF, 16'd1);
    push_cmd(OP_WRITE, 8'd0, 8'd255, MIN_FREQ, 16'd0);
    push_cmd(OP_WRITE, 8'd0, 8'd0, 16'd24, 16'd2);
    push_cmd(OP_WRITE, 8'd0, 8'd1, 16'd0, 16'hFFFF);
    push_cmd(OP_WRITE, 8'd0, 8'd2, 16'd0, 16'd0);
    push_cmd(OP_WRITE, 8'd0, 8'd3, 16'd1000, 16'd3);
    push_cmd(OP_WRITE, 8'd0, 8'd4, 16'd0, 16'd0);
    push_cmd(OP_START, 8'd254, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_START, 8'd3, 8'd0, 16'd0, 16'd0);     // busy, refused
    push_cmd(OP_QUEUE, 8'd3, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_QUEUE, 8'd4, 8'd0, 16'd0, 16'd0);     // song that is only an end word
    push_cmd(OP_QUEUE, 8'd255, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_QUEUE, 8'd3, 8'd0, 16'd0, 16'd0);
    push_cmd(OP_QUEUE, 8'd0, 8'd0, 16'd0, 16'd0);     // queue full
    push_tick(0);
    push_tick(1);
    push_tick(0);
    push_tick(0);           // zero duration ends at once
    push_tick(1);
    push_tick(1);           // time wraps past zero
    push_tick(1);
    push_tick(0);
    push_tick(65534);
    push_tick(1);
    push_tick(0);           // end word pops the queue

    // fill the whole note memory with short songs
    left = $urandom_range(1, 5);
    song_heads.push_back(8'd0);
    for (int a = 0; a < NOTE_DEPTH; a++) begin
      if (left == 0 || a == NOTE_DEPTH - 1) begin
        push_cmd(OP_WRITE, 8'($urandom), 8'(a), 16'd0, 16'd0);
        if (a < NOTE_DEPTH - 1) song_heads.push_back(8'(a + 1));
        left = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5);
      end else begin
        push_cmd(OP_WRITE, 8'($urandom), 8'(a), pick_freq(), pick_dur());
        left--;
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      repeat (PER_PHASE) push_random_command();
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (predicted_status.size() != 0)
      report_mismatch("results never delivered", 0, predicted_status.size());
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
